[rtl/core/pas_pkg.sv]
`default_nettype none

package pas_pkg;

	// Item codes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	// Register indexes on the configuration port
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_PED_EN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACT_EN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AMP_MIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_START = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_END  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DBNC_LIM = 3'd5;
	localparam int CFG_DATA_W = 8;

	// Register reset values
	localparam logic [7:0] AMP_MIN_RST   = 8'd30;
	localparam logic [4:0] WIN_START_RST = 5'd10;
	localparam logic [4:0] WIN_END_RST   = 5'd20;
	localparam logic [3:0] DBNC_LIM_RST  = 4'd5;

	// Activity window
	localparam int WINDOW_SAMPLES = 125;
	// Sums at or above this give an average over 255
	localparam logic [16:0] AVG_SAT_SUM = 17'(256 * WINDOW_SAMPLES);
	// Reciprocal of 125, exact for sums below AVG_SAT_SUM
	localparam int RECIP_SHIFT = 22;
	localparam logic [15:0] RECIP = 16'(((1 << RECIP_SHIFT) + WINDOW_SAMPLES - 1) / WINDOW_SAMPLES);

	typedef struct packed {
		logic       ped_en;
		logic       act_en;
		logic [7:0] amp_min;
		logic [4:0] win_start;
		logic [4:0] win_end;
		logic [3:0] dbnc_lim;
	} cfg_t;

	// Per-request strobes to the pedometer
	typedef struct packed {
		logic go;
		logic clr;
	} step_ctl_t;

	// Activity result for one sample
	typedef struct packed {
		logic       valid;
		logic [7:0] min;
		logic [7:0] max;
		logic [7:0] avg;
	} stats_t;

endpackage

`default_nettype wire

[rtl/core/pedometer_and_activity_stats.sv]
// A request waits in the input register until the result register is free or emptying.
// Throughput: one request per cycle unless out_stall holds a result; a new request is taken
// while a finished result still waits for the receiver, if the input register is free.
// Reset (arst_n low, asynchronous) clears all pipeline valids, the previous sample,
// pedometer and window state, and loads the registers with their defaults.
`default_nettype none

module pedometer_and_activity_stats (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration
	input  wire logic                              cfg_we,
	input  wire logic [pas_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pas_pkg::CFG_DATA_W-1:0]    cfg_data,
	// sample requests
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              op,
	input  wire logic signed [7:0]                 accel_x,
	input  wire logic signed [7:0]                 accel_y,
	input  wire logic signed [7:0]                 accel_z,
	// results
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [15:0]                            step_count,
	output logic                                   walking,
	output logic                                   stats_valid,
	output logic [7:0]                             activity_min,
	output logic [7:0]                             activity_max,
	output logic [7:0]                             activity_avg
);

	pas_pkg::cfg_t      cfg_q;
	pas_pkg::step_ctl_t step_ctl;
	pas_pkg::stats_t    stats;

	logic              valid_s1, op_s1;
	logic signed [7:0] x_s1, y_s1, z_s1;
	logic signed [7:0] prev_x_q, prev_y_q, prev_z_q;
	logic signed [8:0] dx, dy, dz;
	logic              adv, sample, act_go;
	logic [15:0]       steps_next;
	logic              walking_next;

	logic              out_valid_q, walk_q, sv_q;
	logic [15:0]       step_q;
	logic [7:0]        min_q, max_q, avg_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ped_en    <= 1'b0;
			cfg_q.act_en    <= 1'b0;
			cfg_q.amp_min   <= pas_pkg::AMP_MIN_RST;
			cfg_q.win_start <= pas_pkg::WIN_START_RST;
			cfg_q.win_end   <= pas_pkg::WIN_END_RST;
			cfg_q.dbnc_lim  <= pas_pkg::DBNC_LIM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pas_pkg::CFG_PED_EN:    cfg_q.ped_en    <= cfg_data[0];
				pas_pkg::CFG_ACT_EN:    cfg_q.act_en    <= cfg_data[0];
				pas_pkg::CFG_AMP_MIN:   cfg_q.amp_min   <= cfg_data[7:0];
				pas_pkg::CFG_WIN_START: cfg_q.win_start <= cfg_data[4:0];
				pas_pkg::CFG_WIN_END:   cfg_q.win_end   <= cfg_data[4:0];
				pas_pkg::CFG_DBNC_LIM:  cfg_q.dbnc_lim  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Handshake: stage 1 moves on when the result register is free or emptying
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1 <= op;
			x_s1  <= accel_x;
			y_s1  <= accel_y;
			z_s1  <= accel_z;
		end
	end

	// Request decode
	assign sample = adv && (op_s1 == pas_pkg::OP_SAMPLE) && (cfg_q.ped_en || cfg_q.act_en);
	assign step_ctl.go  = adv && (op_s1 == pas_pkg::OP_SAMPLE) && cfg_q.ped_en;
	assign step_ctl.clr = adv && (op_s1 == pas_pkg::OP_CLEAR);
	assign act_go = adv && (op_s1 == pas_pkg::OP_SAMPLE) && cfg_q.act_en;

	// Sample differences
	assign dx = 9'(x_s1) - 9'(prev_x_q);
	assign dy = 9'(y_s1) - 9'(prev_y_q);
	assign dz = 9'(z_s1) - 9'(prev_z_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_z_q <= '0;
		end else if (sample) begin
			prev_x_q <= x_s1;
			prev_y_q <= y_s1;
			prev_z_q <= z_s1;
		end
	end

	pas_pedo u_pedo (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (step_ctl),
		.cfg          (cfg_q),
		.dy           (dy),
		.acc          (prev_y_q),
		.steps_next   (steps_next),
		.walking_next (walking_next)
	);

	pas_act u_act (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (act_go),
		.dx     (dx),
		.dy     (dy),
		.dz     (dz),
		.stats  (stats)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			step_q <= steps_next;
			walk_q <= walking_next;
			sv_q   <= stats.valid;
			min_q  <= stats.min;
			max_q  <= stats.max;
			avg_q  <= stats.avg;
		end
	end

	assign out_valid    = out_valid_q;
	assign step_count   = step_q;
	assign walking      = walk_q;
	assign stats_valid  = sv_q;
	assign activity_min = min_q;
	assign activity_max = max_q;
	assign activity_avg = avg_q;

	// Checks
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("advanced request produced no result");

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && op_s1 == pas_pkg::OP_CLEAR) |=> (step_q == 16'd0))
		else $error("clear request left a nonzero step count");

	a_stats_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (min_q <= max_q && avg_q >= min_q && avg_q <= max_q))
		else $error("window statistics out of order");

	a_stats_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !sv_q) |-> (max_q == 8'd0 && avg_q == 8'd0))
		else $error("statistics nonzero without a closed window");

endmodule

`default_nettype wire

[rtl/core/pas_pedo.sv]
`default_nettype none

module pas_pedo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pas_pkg::step_ctl_t ctl,
	input  wire pas_pkg::cfg_t      cfg,
	input  wire logic signed [8:0]  dy,
	input  wire logic signed [7:0]  acc,
	output logic [15:0]             steps_next,
	output logic                    walking_next
);

	typedef struct packed {
		logic [15:0] steps;
		logic [7:0]  dbc;
		logic        expect_hi;
		logic        walking;
	} ped_cnt_t;

	function automatic logic [6:0] age_inc(input logic [6:0] a);
		return (a == 7'h7f) ? a : a + 7'd1;
	endfunction

	// One judged peak window
	function automatic ped_cnt_t judge(input ped_cnt_t s, input logic good,
			input logic [3:0] lim);
		ped_cnt_t r;
		r = s;
		if (good) begin
			if (r.walking) begin
				r.steps = r.steps + 16'd1;
				r.dbc = {4'b0, lim};
			end else begin
				if (r.dbc != 8'hff)
					r.dbc = r.dbc + 8'd1;
				if (r.dbc >= {4'b0, lim}) begin
					r.walking = 1'b1;
					r.steps = r.steps + {8'b0, r.dbc};
				end
			end
			r.expect_hi = !r.expect_hi;
		end else if (r.dbc != 8'd0) begin
			r.dbc = r.dbc - 8'd1;
			if (r.dbc == 8'd0)
				r.walking = 1'b0;
		end
		return r;
	endfunction

	localparam logic signed [7:0] PEAK_FLOOR = -8'sd128;
	localparam logic signed [7:0] PEAK_CEIL  = 8'sd127;

	logic signed [1:0] last_dir_q, dir, last_dir_n;
	logic signed [7:0] ph_q, pl_q, ch_q, cl_q;
	logic signed [7:0] ph_n, pl_n, ch_n, cl_n;
	logic [6:0]        pha_q, pla_q, cha_q, cla_q;
	logic [6:0]        pha_n, pla_n, cha_n, cla_n;
	ped_cnt_t          cnt_q, cnt_n;
	logic              up_peak, down_peak;
	logic signed [9:0] amp_s, swing_hi, swing_lo;
	logic [6:0]        start_w, end_w;

	// Slope direction and peak detection
	always_comb begin
		if (dy > 9'sd0)
			dir = 2'sd1;
		else if (dy < 9'sd0)
			dir = -2'sd1;
		else
			dir = 2'sd0;
		up_peak   = !last_dir_q[1] && dir[1];
		down_peak = (last_dir_q <= 2'sd0) && (dir == 2'sd1);
	end

	assign amp_s   = $signed({2'b00, cfg.amp_min});
	assign start_w = {2'b00, cfg.win_start};
	assign end_w   = {2'b00, cfg.win_end};

	// Next pedometer state
	always_comb begin
		last_dir_n = last_dir_q;
		ph_n = ph_q;  pl_n = pl_q;  ch_n = ch_q;  cl_n = cl_q;
		pha_n = pha_q; pla_n = pla_q; cha_n = cha_q; cla_n = cla_q;
		cnt_n = cnt_q;
		swing_hi = '0;
		swing_lo = '0;
		if (ctl.clr) begin
			cnt_n.steps = '0;
		end else if (ctl.go) begin
			if (cnt_q.dbc != 8'd0) begin
				pha_n = age_inc(pha_q);
				pla_n = age_inc(pla_q);
				cha_n = age_inc(cha_q);
				cla_n = age_inc(cla_q);
				// high peak: improve the peak or track a candidate
				if (up_peak) begin
					if (pha_n < start_w) begin
						if (acc > ph_n) begin
							ph_n = acc;
							pha_n = '0;
							ch_n = PEAK_FLOOR;
							cha_n = '0;
						end
					end else if (pha_n <= end_w && acc > ch_n) begin
						ch_n = acc;
						cha_n = '0;
					end
				end
				// low peak
				if (down_peak) begin
					if (pla_n < start_w) begin
						if (acc < pl_n) begin
							pl_n = acc;
							pla_n = '0;
							cl_n = PEAK_CEIL;
							cla_n = '0;
						end
					end else if (pla_n <= end_w && acc < cl_n) begin
						cl_n = acc;
						cla_n = '0;
					end
				end
				// high window closed
				if (pha_n > end_w) begin
					swing_hi = 10'(ch_n) - 10'(pl_n);
					cnt_n = judge(cnt_n, cnt_n.expect_hi && (swing_hi > amp_s),
						cfg.dbnc_lim);
					ph_n = ch_n;
					pha_n = cha_n;
					ch_n = PEAK_FLOOR;
					cha_n = '0;
				end
				// low window closed
				if (pla_n > end_w) begin
					swing_lo = 10'(ph_n) - 10'(cl_n);
					cnt_n = judge(cnt_n, !cnt_n.expect_hi && (swing_lo > amp_s),
						cfg.dbnc_lim);
					pl_n = cl_n;
					pla_n = cla_n;
					cl_n = PEAK_CEIL;
					cla_n = '0;
				end
			end else begin
				// first peak starts the search
				if (up_peak) begin
					cnt_n.dbc = cnt_n.dbc + 8'd1;
					cnt_n.expect_hi = 1'b0;
					ph_n = acc;
					pha_n = '0;
					ch_n = PEAK_FLOOR;
					cha_n = '0;
				end
				if (down_peak) begin
					cnt_n.dbc = cnt_n.dbc + 8'd1;
					cnt_n.expect_hi = 1'b1;
					pl_n = acc;
					pla_n = '0;
					cl_n = PEAK_CEIL;
					cla_n = '0;
				end
			end
			last_dir_n = dir;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_dir_q <= '0;
			ph_q <= '0;
			pl_q <= '0;
			ch_q <= PEAK_FLOOR;
			cl_q <= PEAK_CEIL;
			pha_q <= '0;
			pla_q <= '0;
			cha_q <= '0;
			cla_q <= '0;
			cnt_q <= '0;
		end else begin
			last_dir_q <= last_dir_n;
			ph_q <= ph_n;
			pl_q <= pl_n;
			ch_q <= ch_n;
			cl_q <= cl_n;
			pha_q <= pha_n;
			pla_q <= pla_n;
			cha_q <= cha_n;
			cla_q <= cla_n;
			cnt_q <= cnt_n;
		end
	end

	assign steps_next   = cnt_n.steps;
	assign walking_next = cnt_n.walking;

endmodule

`default_nettype wire

[rtl/core/pas_act.sv]
`default_nettype none

module pas_act (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               go,
	input  wire logic signed [8:0]  dx,
	input  wire logic signed [8:0]  dy,
	input  wire logic signed [8:0]  dz,
	output pas_pkg::stats_t         stats
);

	logic [6:0]  cnt_q, cnt_n;
	logic [16:0] sum_q, sum_n;
	logic [9:0]  min_q, min_n, max_q, max_n;
	logic [8:0]  ax, ay, az;
	logic [9:0]  delta;
	logic        close;
	logic [30:0] prod;

	// Activity delta |dx|+|dy|+|dz|
	assign ax = dx[8] ? 9'(-dx) : 9'(dx);
	assign ay = dy[8] ? 9'(-dy) : 9'(dy);
	assign az = dz[8] ? 9'(-dz) : 9'(dz);
	assign delta = 10'(ax) + 10'(ay) + 10'(az);

	// Window accumulation
	always_comb begin
		cnt_n = cnt_q;
		sum_n = sum_q;
		min_n = min_q;
		max_n = max_q;
		if (go) begin
			cnt_n = cnt_q + 7'd1;
			sum_n = sum_q + 17'(delta);
			if (delta < min_q)
				min_n = delta;
			if (delta > max_q)
				max_n = delta;
		end
	end

	assign close = go && (cnt_n >= 7'(pas_pkg::WINDOW_SAMPLES));

	// Average by reciprocal multiply, saturated
	assign prod = 31'(sum_n[14:0]) * 31'(pas_pkg::RECIP);

	always_comb begin
		stats = '0;
		if (close) begin
			stats.valid = 1'b1;
			stats.min = (|min_n[9:8]) ? 8'hff : min_n[7:0];
			stats.max = (|max_n[9:8]) ? 8'hff : max_n[7:0];
			if (sum_n >= pas_pkg::AVG_SAT_SUM)
				stats.avg = 8'hff;
			else
				stats.avg = prod[pas_pkg::RECIP_SHIFT +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
			min_q <= '1;
			max_q <= '0;
		end else if (close) begin
			cnt_q <= '0;
			sum_q <= '0;
			min_q <= '1;
			max_q <= '0;
		end else begin
			cnt_q <= cnt_n;
			sum_q <= sum_n;
			min_q <= min_n;
			max_q <= max_n;
		end
	end

endmodule

`default_nettype wire
